FILE: hw/rtl/mandelbrot_pixel_engine_unit_defines.svh
// Assertion macros shared by the mandelbrot pixel engine RTL.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef MANDELBROT_PIXEL_ENGINE_UNIT_DEFINES_SVH
`define MANDELBROT_PIXEL_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MPE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mpe_pkg.sv
// Package for the mandelbrot pixel engine: widths, register codes,
// reset values, shade lookup and core state type. No dependencies.
`timescale 1ns / 1ps
package mpe_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int PIX_IDX_BITS_DEF = 10;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int COORD_W   = 32;
  localparam int STEP_W    = 20;
  localparam int ITER_W    = 8;
  localparam int CHAR_W    = 7;
  localparam int DIGIT_W   = 4;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_X_ORIGIN = 3'd0;
  localparam logic [2:0] REG_Y_ORIGIN = 3'd1;
  localparam logic [2:0] REG_X_STEP   = 3'd2;
  localparam logic [2:0] REG_Y_STEP   = 3'd3;
  localparam logic [2:0] REG_MAX_ITER = 3'd4;

  localparam logic signed [COORD_W-1:0] X_ORIGIN_RST = -32'sd131072;
  localparam logic signed [COORD_W-1:0] Y_ORIGIN_RST = -32'sd65536;
  localparam logic [STEP_W-1:0]         X_STEP_RST   = 20'd2520;
  localparam logic [STEP_W-1:0]         Y_STEP_RST   = 20'd4681;
  localparam logic [ITER_W-1:0]         MAX_ITER_RST = 8'd32;

  localparam logic [DIGIT_W-1:0] DIGIT_LAST = 4'd9;
  localparam logic [CHAR_W-1:0]  CHAR_SPACE = 7'd32;

  // " .:-=+*#%@" indexed by count mod 10
  localparam logic [CHAR_W-1:0] SHADE_LUT [0:9] = '{
    7'd32, 7'd46, 7'd58, 7'd45, 7'd61, 7'd43, 7'd42, 7'd35, 7'd37, 7'd64
  };

  typedef enum logic {
    CORE_IDLE,
    CORE_RUN
  } core_state_t;

endpackage

FILE: hw/rtl/mandelbrot_pixel_engine_unit.sv
// Mandelbrot escape-time pixel engine, usage notes:
// - Pixel channel: push/full, fields in_pixel_col/in_pixel_row. A transaction
//   goes in when push is high and full is low.
// - Result channel: empty/pop. While empty is low the oldest result sits on the
//   out_* ports; pop with empty low takes it. Exactly one result per pixel.
// - Config: APB-style write port, registers at byte 4*i (x_origin, y_origin,
//   x_step, y_step, max_iter). Write only when the engine is drained.
// - Path: the front register, then the job queue into the core, which runs
//   n iteration steps, n = iterations done (at most max_iter).
// - Pixel rate: set by the single iteration loop (three 32x32 products, one
//   step per cycle); the front end and queue take in and line up new pixels
//   while the core works on one, so the core never waits on the input side.
// - Stalls: a result that is not popped holds the core at its final step; the
//   queue then fills and full rises. Nothing is dropped.
// - Reset (rst_n low, synchronous): queues empty, core idle, registers return
//   to their defaults (-2.0, -1.0, 2520, 4681, 32).
// Depends on mpe_pkg, mpe_front, mpe_fifo, mpe_core.
`timescale 1ns / 1ps
module mandelbrot_pixel_engine_unit #(
  parameter int FRAC_BITS        = mpe_pkg::FRAC_BITS_DEF,
  parameter int PIXEL_INDEX_BITS = mpe_pkg::PIX_IDX_BITS_DEF,
  parameter int QUEUE_DEPTH      = mpe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // pixel channel
  input  logic                                push,
  output logic                                full,
  input  logic [PIXEL_INDEX_BITS-1:0]         in_pixel_col,
  input  logic [PIXEL_INDEX_BITS-1:0]         in_pixel_row,
  // result channel
  output logic                                empty,
  input  logic                                pop,
  output logic [mpe_pkg::ITER_W-1:0]          out_iter_count,
  output logic                                out_interior,
  output logic [mpe_pkg::CHAR_W-1:0]          out_shade_char,
  output logic [PIXEL_INDEX_BITS-1:0]         out_col_tag,
  output logic [PIXEL_INDEX_BITS-1:0]         out_row_tag,
  // config port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mpe_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [mpe_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [mpe_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import mpe_pkg::*;

  localparam int JOB_W = 2 * COORD_W + 2 * PIXEL_INDEX_BITS;

  // ---------------- configuration registers ----------------
  logic signed [COORD_W-1:0] x_origin_r, x_origin_nxt, y_origin_r, y_origin_nxt;
  logic [STEP_W-1:0]         x_step_r, x_step_nxt, y_step_r, y_step_nxt;
  logic [ITER_W-1:0]         max_iter_r, max_iter_nxt;
  logic                      cfg_wr;
  logic [2:0]                reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[CFG_ADDR_W-1:2];

  always_comb begin
    x_origin_nxt = x_origin_r;
    y_origin_nxt = y_origin_r;
    x_step_nxt   = x_step_r;
    y_step_nxt   = y_step_r;
    max_iter_nxt = max_iter_r;
    if (cfg_wr) begin
      case (reg_sel)
        REG_X_ORIGIN: x_origin_nxt = $signed(pwdata);
        REG_Y_ORIGIN: y_origin_nxt = $signed(pwdata);
        REG_X_STEP:   x_step_nxt   = pwdata[STEP_W-1:0];
        REG_Y_STEP:   y_step_nxt   = pwdata[STEP_W-1:0];
        REG_MAX_ITER: max_iter_nxt = pwdata[ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= X_ORIGIN_RST;
      y_origin_r <= Y_ORIGIN_RST;
      x_step_r   <= X_STEP_RST;
      y_step_r   <= Y_STEP_RST;
      max_iter_r <= MAX_ITER_RST;
    end else begin
      x_origin_r <= x_origin_nxt;
      y_origin_r <= y_origin_nxt;
      x_step_r   <= x_step_nxt;
      y_step_r   <= y_step_nxt;
      max_iter_r <= max_iter_nxt;
    end
  end

  // read-back mux; unmapped addresses read zero
  always_comb begin
    case (reg_sel)
      REG_X_ORIGIN: prdata = x_origin_r;
      REG_Y_ORIGIN: prdata = y_origin_r;
      REG_X_STEP:   prdata = CFG_DATA_W'(x_step_r);
      REG_Y_STEP:   prdata = CFG_DATA_W'(y_step_r);
      REG_MAX_ITER: prdata = CFG_DATA_W'(max_iter_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------- front end -> job queue -> core ----------------
  logic             job_push, job_full, job_pop, job_empty;
  logic [JOB_W-1:0] job_in, job_out;

  mpe_front #(
    .PIXEL_INDEX_BITS(PIXEL_INDEX_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_pixel_col (in_pixel_col),
    .in_pixel_row (in_pixel_row),
    .x_origin     (x_origin_r),
    .y_origin     (y_origin_r),
    .x_step       (x_step_r),
    .y_step       (y_step_r),
    .job_push     (job_push),
    .job_data     (job_in),
    .job_full     (job_full)
  );

  mpe_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .empty   (job_empty)
  );

  mpe_core #(
    .FRAC_BITS        (FRAC_BITS),
    .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_data       (job_out),
    .job_empty      (job_empty),
    .job_pop        (job_pop),
    .max_iter       (max_iter_r),
    .empty          (empty),
    .pop            (pop),
    .out_iter_count (out_iter_count),
    .out_interior   (out_interior),
    .out_shade_char (out_shade_char),
    .out_col_tag    (out_col_tag),
    .out_row_tag    (out_row_tag)
  );

endmodule

FILE: hw/rtl/mpe_front.sv
// Front end of the pixel engine: accepts pixel transactions and forms c.
// Depends on mpe_pkg; feeds the job queue (mpe_fifo).
`timescale 1ns / 1ps
module mpe_front #(
  parameter int PIXEL_INDEX_BITS = mpe_pkg::PIX_IDX_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    push,
  output logic                                    full,
  input  logic [PIXEL_INDEX_BITS-1:0]             in_pixel_col,
  input  logic [PIXEL_INDEX_BITS-1:0]             in_pixel_row,
  input  logic signed [mpe_pkg::COORD_W-1:0]      x_origin,
  input  logic signed [mpe_pkg::COORD_W-1:0]      y_origin,
  input  logic [mpe_pkg::STEP_W-1:0]              x_step,
  input  logic [mpe_pkg::STEP_W-1:0]              y_step,
  output logic                                    job_push,
  output logic [2*mpe_pkg::COORD_W+2*PIXEL_INDEX_BITS-1:0] job_data,
  input  logic                                    job_full
);
  import mpe_pkg::*;

  localparam int PROD_W = STEP_W + PIXEL_INDEX_BITS;

  logic                        v_r, v_nxt;
  logic [COORD_W-1:0]          cre_r, cre_nxt, cim_r, cim_nxt;
  logic [PIXEL_INDEX_BITS-1:0] col_r, row_r;
  logic [PROD_W-1:0]           xprod, yprod;
  logic                        take;

  assign xprod = x_step * in_pixel_col;
  assign yprod = y_step * in_pixel_row;

  assign job_push = v_r && !job_full;
  assign full     = v_r && job_full;
  assign take     = push && !full;

  always_comb begin
    v_nxt   = take || (v_r && job_full);
    cre_nxt = x_origin + COORD_W'(xprod);
    cim_nxt = y_origin + COORD_W'(yprod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cre_r <= cre_nxt;
      cim_r <= cim_nxt;
      col_r <= in_pixel_col;
      row_r <= in_pixel_row;
    end
  end

  assign job_data = {cre_r, cim_r, col_r, row_r};

endmodule

FILE: hw/rtl/mpe_fifo.sv
// Short job queue between the front end and the iteration core.
// Generic width and depth; depends on nothing.
`timescale 1ns / 1ps
module mpe_fifo #(
  parameter int WIDTH = 84,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_r [0:DEPTH-1];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? ((wp_r == PTR_LAST) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = do_rd ? ((rp_r == PTR_LAST) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + CNT_W'(do_wr) - CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_data;
    end
  end

endmodule

FILE: hw/rtl/mpe_core.sv
// Iteration core: runs z = z^2 + c one step per cycle, holds the result.
// Depends on mpe_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "mandelbrot_pixel_engine_unit_defines.svh"
module mpe_core #(
  parameter int FRAC_BITS        = mpe_pkg::FRAC_BITS_DEF,
  parameter int PIXEL_INDEX_BITS = mpe_pkg::PIX_IDX_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [2*mpe_pkg::COORD_W+2*PIXEL_INDEX_BITS-1:0] job_data,
  input  logic                                    job_empty,
  output logic                                    job_pop,
  input  logic [mpe_pkg::ITER_W-1:0]              max_iter,
  output logic                                    empty,
  input  logic                                    pop,
  output logic [mpe_pkg::ITER_W-1:0]              out_iter_count,
  output logic                                    out_interior,
  output logic [mpe_pkg::CHAR_W-1:0]              out_shade_char,
  output logic [PIXEL_INDEX_BITS-1:0]             out_col_tag,
  output logic [PIXEL_INDEX_BITS-1:0]             out_row_tag
);
  import mpe_pkg::*;

  localparam int PROD_W = 2 * COORD_W;
  localparam logic signed [COORD_W:0] ESC_LIMIT = (COORD_W+1)'(4) << FRAC_BITS;

  core_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic [COORD_W-1:0]          cre_r, cre_nxt, cim_r, cim_nxt;
  logic [ITER_W-1:0]           n_r, n_nxt;
  logic [DIGIT_W-1:0]          dig_r, dig_nxt;
  logic [PIXEL_INDEX_BITS-1:0] col_r, col_nxt, row_r, row_nxt;

  logic                        out_v_r, out_v_nxt;
  logic [ITER_W-1:0]           out_count_r;
  logic                        out_interior_r;
  logic [CHAR_W-1:0]           out_shade_r;
  logic [PIXEL_INDEX_BITS-1:0] out_col_r, out_row_r;

  logic signed [PROD_W-1:0]    xx, yy, xy;
  logic [COORD_W-1:0]          x2, y2, xyq;
  logic signed [COORD_W:0]     mag;
  logic                        at_limit, escaped, finish, slot_free, commit;

  assign xx  = x_r * x_r;
  assign yy  = y_r * y_r;
  assign xy  = x_r * y_r;
  assign x2  = xx[FRAC_BITS+COORD_W-1:FRAC_BITS];
  assign y2  = yy[FRAC_BITS+COORD_W-1:FRAC_BITS];
  assign xyq = xy[FRAC_BITS+COORD_W-1:FRAC_BITS];
  assign mag = $signed({x2[COORD_W-1], x2}) + $signed({y2[COORD_W-1], y2});

  assign at_limit  = (n_r == max_iter);
  assign escaped   = (mag > ESC_LIMIT);
  assign finish    = at_limit || escaped;
  assign slot_free = !out_v_r || pop;
  assign commit    = (state_r == CORE_RUN) && finish && slot_free;

  always_comb begin
    state_nxt = state_r;
    job_pop   = 1'b0;
    x_nxt     = x_r;
    y_nxt     = y_r;
    cre_nxt   = cre_r;
    cim_nxt   = cim_r;
    n_nxt     = n_r;
    dig_nxt   = dig_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    case (state_r)
      CORE_IDLE: begin
        if (!job_empty) begin
          job_pop   = 1'b1;
          {cre_nxt, cim_nxt, col_nxt, row_nxt} = job_data;
          x_nxt     = '0;
          y_nxt     = '0;
          n_nxt     = '0;
          dig_nxt   = '0;
          state_nxt = CORE_RUN;
        end
      end
      CORE_RUN: begin
        if (finish) begin
          // result stays put until the output slot frees up
          if (slot_free) begin
            state_nxt = CORE_IDLE;
          end
        end else begin
          x_nxt   = $signed(x2 - y2 + cre_r);
          y_nxt   = $signed({xyq[COORD_W-2:0], 1'b0} + cim_r);
          n_nxt   = n_r + 1'b1;
          dig_nxt = (dig_r == DIGIT_LAST) ? '0 : dig_r + 1'b1;
        end
      end
      default: begin
        state_nxt = CORE_IDLE;
      end
    endcase
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (commit) begin
      out_v_nxt = 1'b1;
    end else if (pop && out_v_r) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CORE_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    cre_r <= cre_nxt;
    cim_r <= cim_nxt;
    n_r   <= n_nxt;
    dig_r <= dig_nxt;
    col_r <= col_nxt;
    row_r <= row_nxt;
    if (commit) begin
      out_count_r    <= n_r;
      out_interior_r <= at_limit;
      out_shade_r    <= at_limit ? CHAR_SPACE : SHADE_LUT[dig_r];
      out_col_r      <= col_r;
      out_row_r      <= row_r;
    end
  end

  assign empty          = !out_v_r;
  assign out_iter_count = out_count_r;
  assign out_interior   = out_interior_r;
  assign out_shade_char = out_shade_r;
  assign out_col_tag    = out_col_r;
  assign out_row_tag    = out_row_r;

  `MPE_ASSERT_IMPL(a_iter_bound, state_r == CORE_RUN, n_r <= max_iter,
                   "iteration count passed the limit")
  `MPE_ASSERT_IMPL(a_digit_range, state_r == CORE_RUN, dig_r <= DIGIT_LAST,
                   "mod-10 digit out of range")
  `MPE_ASSERT_IMPL(a_interior_flag, out_v_r, out_interior_r == (out_count_r == max_iter),
                   "interior flag disagrees with count")
  `MPE_ASSERT_NEXT(a_commit_shows, commit, out_v_r,
                   "committed result not presented")

endmodule
